/* sv/kufe_pkg.sv */
package kufe_pkg;

  // width of a stored tree size (sizes wrap at this width)
  localparam int SizeW = 11;
  localparam int VtxW = 11;
  localparam int CountW = 11;
  localparam int SlotW = 10;

  // result status codes
  localparam logic [1:0] STAT_ACCEPTED  = 2'd0;
  localparam logic [1:0] STAT_SAME_TREE = 2'd1;
  localparam logic [1:0] STAT_COMPLETE  = 2'd2;
  localparam logic [1:0] STAT_BAD_VTX   = 2'd3;

  // configuration register indexes
  localparam logic [0:0] CFG_VERTEX_COUNT = 1'd0;
  localparam logic [0:0] CFG_TARGET_EDGES = 1'd1;

  // write strobes toward the forest store
  typedef struct packed {
    logic par_we;
    logic size_we;
  } kufe_wr_t;

endpackage

/* sv/kufe_forest.sv */
module kufe_forest import kufe_pkg::*; #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  kufe_wr_t                        wr_i,
  input  logic [$clog2(MAX_VERTICES)-1:0] rd_addr_i,
  input  logic [$clog2(MAX_VERTICES)-1:0] par_waddr_i,
  input  logic [$clog2(MAX_VERTICES)-1:0] par_wdata_i,
  input  logic [$clog2(MAX_VERTICES)-1:0] size_waddr_i,
  input  logic [SizeW-1:0]                size_wdata_i,
  output logic [$clog2(MAX_VERTICES)-1:0] par_rdata_o,
  output logic [SizeW-1:0]                size_rdata_o
);

  localparam int AW = $clog2(MAX_VERTICES);

  logic [AW-1:0]    par_mem  [MAX_VERTICES];
  logic [SizeW-1:0] size_mem [MAX_VERTICES];
  logic [AW-1:0]    par_rd_q;
  logic [SizeW-1:0] size_rd_q;

  // parent store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.par_we) begin
      par_mem[par_waddr_i] <= par_wdata_i;
    end
    par_rd_q <= par_mem[rd_addr_i];
  end

  // size store, read at the same address as the parent store
  always_ff @(posedge clk_i) begin
    if (wr_i.size_we) begin
      size_mem[size_waddr_i] <= size_wdata_i;
    end
    size_rd_q <= size_mem[rd_addr_i];
  end

  assign par_rdata_o  = par_rd_q;
  assign size_rdata_o = size_rd_q;

`ifndef SYNTHESIS
  // a store write always comes with a defined address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.par_we |-> !$isunknown(par_waddr_i))
    else $error("parent write with unknown address");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.size_we |-> !$isunknown(size_waddr_i))
    else $error("size write with unknown address");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.par_we && wr_i.size_we && (par_wdata_i == par_waddr_i) |->
      (size_waddr_i == par_waddr_i))
    else $error("clear sweep writes two different entries");
`endif

endmodule

/* sv/kruskal_union_find_edge_filter.sv */
// channel  | handshake                  | payload
// ---------+----------------------------+-----------------------------------------------
// input    | in_valid_i / in_stall_o    | first_vertex_i second_vertex_i edge_cost_i
//          |                            | restart_i last_edge_i
// output   | out_valid_o / out_stall_i  | status_o slot_o out_first_vertex_o
//          |                            | out_second_vertex_o out_cost_o edges_in_tree_o finished_o
// config   | cfg_we_i                   | cfg_idx_i cfg_data_i
//
// an edge goes from transfer to transfer through check, a read of each node on both root
// walks, merge, hand-off and idle; a same-tree edge skips the merge and a bad or ignored
// edge skips the walks and the merge
// reset and every restart run a clearing pass over all MAX_VERTICES entries of the forest store,
// one entry a cycle, with the input stalled
// the done state holds until the output register is free or being emptied; the result then
// waits there while the next edge is taken
module kruskal_union_find_edge_filter import kufe_pkg::*; #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [VtxW-1:0]     first_vertex_i,
  input  logic [VtxW-1:0]     second_vertex_i,
  input  logic [31:0]         edge_cost_i,
  input  logic                restart_i,
  input  logic                last_edge_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic [SlotW-1:0]    slot_o,
  output logic [VtxW-1:0]     out_first_vertex_o,
  output logic [VtxW-1:0]     out_second_vertex_o,
  output logic [31:0]         out_cost_o,
  output logic [CountW-1:0]   edges_in_tree_o,
  output logic                finished_o,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [10:0]         cfg_data_i
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam logic [AW-1:0] LastIdx = AW'(MAX_VERTICES - 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CLEAR  = 3'd1;
  localparam logic [2:0] ST_CHECK  = 3'd2;
  localparam logic [2:0] ST_WALK_A = 3'd3;
  localparam logic [2:0] ST_WALK_B = 3'd4;
  localparam logic [2:0] ST_MERGE  = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic              pend_q, pend_d;
  logic [CountW-1:0] count_q, count_d;
  logic [10:0]       vcnt_q;
  logic [9:0]        tgt_q;

  // latched edge
  logic [VtxW-1:0]   va_q, vb_q;
  logic [31:0]       cost_q;
  logic              last_q;

  // walk and merge registers
  logic [AW-1:0]     cur_q, cur_d;
  logic [AW-1:0]     root_a_q, root_a_d;
  logic [SizeW-1:0]  size_a_q, size_a_d;
  logic [SizeW-1:0]  size_b_q, size_b_d;
  logic [1:0]        stat_q, stat_d;
  logic [SlotW-1:0]  slot_q, slot_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [1:0]        out_stat_q;
  logic [SlotW-1:0]  out_slot_q;
  logic [VtxW-1:0]   out_va_q, out_vb_q;
  logic [31:0]       out_cost_q;
  logic [CountW-1:0] out_count_q;
  logic              out_fin_q;

  // forest store interface
  kufe_wr_t          wr;
  logic [AW-1:0]     rd_addr, par_waddr, par_wdata, size_waddr, par_rdata;
  logic [SizeW-1:0]  size_wdata, size_rdata;

  logic              in_xfer, out_load, bad_vtx, at_target;
  logic [AW-1:0]     a_idx, b_idx;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // vertex numbers are 1-based; a good vertex is below MAX_VERTICES after the decrement
  assign a_idx = AW'(32'(va_q) - 32'd1);
  assign b_idx = AW'(32'(vb_q) - 32'd1);

  assign at_target = (count_q >= {1'b0, tgt_q});
  assign bad_vtx   = (va_q == '0) || (vb_q == '0) ||
                     (va_q > vcnt_q) || (vb_q > vcnt_q) ||
                     (32'(va_q) > 32'(MAX_VERTICES)) || (32'(vb_q) > 32'(MAX_VERTICES));

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    pend_d     = pend_q;
    count_d    = count_q;
    cur_d      = cur_q;
    root_a_d   = root_a_q;
    size_a_d   = size_a_q;
    size_b_d   = size_b_q;
    stat_d     = stat_q;
    slot_d     = slot_q;
    rd_addr    = cur_q;
    wr         = '0;
    par_waddr  = clr_q;
    par_wdata  = clr_q;
    size_waddr = clr_q;
    size_wdata = SizeW'(1);

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (restart_i) begin
            // restart clears the forest before the edge is handled
            clr_d   = '0;
            pend_d  = 1'b1;
            count_d = '0;
            state_d = ST_CLEAR;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CLEAR: begin
        // every vertex its own root of size one
        wr.par_we  = 1'b1;
        wr.size_we = 1'b1;
        if (clr_q == LastIdx) begin
          pend_d  = 1'b0;
          state_d = pend_q ? ST_CHECK : ST_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      ST_CHECK: begin
        slot_d = '0;
        if (at_target) begin
          // forest complete wins over the vertex check
          stat_d  = STAT_COMPLETE;
          state_d = ST_DONE;
        end else if (bad_vtx) begin
          stat_d  = STAT_BAD_VTX;
          state_d = ST_DONE;
        end else begin
          cur_d   = a_idx;
          rd_addr = a_idx;
          state_d = ST_WALK_A;
        end
      end
      ST_WALK_A: begin
        // read data belongs to cur_q; a self parent marks the root
        if (par_rdata == cur_q) begin
          root_a_d = cur_q;
          size_a_d = size_rdata;
          cur_d    = b_idx;
          rd_addr  = b_idx;
          state_d  = ST_WALK_B;
        end else begin
          cur_d   = par_rdata;
          rd_addr = par_rdata;
        end
      end
      ST_WALK_B: begin
        if (par_rdata == cur_q) begin
          if (cur_q == root_a_q) begin
            stat_d  = STAT_SAME_TREE;
            state_d = ST_DONE;
          end else begin
            // cur_q holds the second root from here on
            size_b_d = size_rdata;
            state_d  = ST_MERGE;
          end
        end else begin
          cur_d   = par_rdata;
          rd_addr = par_rdata;
        end
      end
      ST_MERGE: begin
        // smaller tree hangs below the larger, ties go under the first root
        wr.par_we  = 1'b1;
        wr.size_we = 1'b1;
        size_wdata = size_a_q + size_b_q;
        if (size_a_q < size_b_q) begin
          par_waddr  = root_a_q;
          par_wdata  = cur_q;
          size_waddr = cur_q;
        end else begin
          par_waddr  = cur_q;
          par_wdata  = root_a_q;
          size_waddr = root_a_q;
        end
        stat_d  = STAT_ACCEPTED;
        slot_d  = count_q[SlotW-1:0];
        count_d = (count_q == '1) ? count_q : count_q + CountW'(1);
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  kufe_forest #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_forest (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (wr),
    .rd_addr_i    (rd_addr),
    .par_waddr_i  (par_waddr),
    .par_wdata_i  (par_wdata),
    .size_waddr_i (size_waddr),
    .size_wdata_i (size_wdata),
    .par_rdata_o  (par_rdata),
    .size_rdata_o (size_rdata)
  );

  // control state; reset starts with a clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      pend_q  <= 1'b0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
      count_q <= count_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q <= 11'd1024;
      tgt_q  <= 10'd1023;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VERTEX_COUNT: vcnt_q <= cfg_data_i;
        CFG_TARGET_EDGES: tgt_q  <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // edge capture on the input transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      va_q   <= first_vertex_i;
      vb_q   <= second_vertex_i;
      cost_q <= edge_cost_i;
      last_q <= last_edge_i;
    end
  end

  // walk and merge work registers
  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    root_a_q <= root_a_d;
    size_a_q <= size_a_d;
    size_b_q <= size_b_d;
    stat_q   <= stat_d;
    slot_q   <= slot_d;
  end

  // output register: filled from the sequencer, emptied by the output transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_stat_q  <= stat_q;
      out_slot_q  <= slot_q;
      out_va_q    <= va_q;
      out_vb_q    <= vb_q;
      out_cost_q  <= cost_q;
      out_count_q <= count_q;
      out_fin_q   <= last_q || at_target;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = out_stat_q;
  assign slot_o              = out_slot_q;
  assign out_first_vertex_o  = out_va_q;
  assign out_second_vertex_o = out_vb_q;
  assign out_cost_o          = out_cost_q;
  assign edges_in_tree_o     = out_count_q;
  assign finished_o          = out_fin_q;

`ifndef SYNTHESIS
  // an accepted edge takes the slot just below the new count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_ACCEPTED) |->
      (CountW'(slot_o) + CountW'(1) == edges_in_tree_o))
    else $error("accepted slot does not match edge count");
  // only an accepted edge carries a slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_ACCEPTED) |-> (slot_o == '0))
    else $error("slot set on an edge that was not accepted");
  // a complete forest always reports finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STAT_COMPLETE) |-> finished_o)
    else $error("forest complete without finished");
  // a new result only comes out of the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result loaded outside the done state");
  // the count only moves on a merge or a restart
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      ($past(state_q) == ST_MERGE) || ($past(state_q) == ST_IDLE))
    else $error("edge count changed outside merge or restart");
`endif

endmodule

/* tb/sv/tb_kruskal_union_find_edge_filter.sv */
module tb_kruskal_union_find_edge_filter;
  import kufe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxVtx = 1024;

  // one edge as it goes into the block
  typedef struct packed {
    logic [VtxW-1:0] va;
    logic [VtxW-1:0] vb;
    logic [31:0]     cost;
    logic            restart;
    logic            last_e;
  } edge_item_t;

  // one verdict as it comes out of the block
  typedef struct packed {
    logic [1:0]        status;
    logic [SlotW-1:0]  slot;
    logic [VtxW-1:0]   va;
    logic [VtxW-1:0]   vb;
    logic [31:0]       cost;
    logic [CountW-1:0] count;
    logic              finished;
  } verdict_t;

  // clock, reset and dut ports, all known from time zero
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall_o;
  logic [VtxW-1:0]   first_v = '0;
  logic [VtxW-1:0]   second_v = '0;
  logic [31:0]       cost_v = '0;
  logic              restart_v = 1'b0;
  logic              last_v = 1'b0;
  logic              out_valid_o;
  logic              out_stall = 1'b0;
  logic [1:0]        status_o;
  logic [SlotW-1:0]  slot_o;
  logic [VtxW-1:0]   out_first_o;
  logic [VtxW-1:0]   out_second_o;
  logic [31:0]       out_cost_o;
  logic [CountW-1:0] edges_in_tree_o;
  logic              finished_o;
  logic              cfg_we = 1'b0;
  logic [0:0]        cfg_idx = CFG_VERTEX_COUNT;
  logic [10:0]       cfg_data = '0;

  // shadow forest: parent links, tree sizes, accepted edge count and registers
  logic [9:0]        parent_of [MaxVtx];
  logic [SizeW-1:0]  tree_sz [MaxVtx];
  logic [CountW-1:0] kept;
  logic [10:0]       vtx_count = 11'd1024;
  logic [9:0]        tgt_edges = 10'd1023;

  edge_item_t pending_edges[$];
  verdict_t   expected_verdicts[$];

  int gap_pct = 26;
  int errors = 0;
  int n_items = 0;
  int n_checked = 0;
  int n_restarts = 0;
  int n_writes = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int cycle_count = 0;
  int cycle_limit = 40000;

  kruskal_union_find_edge_filter dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall_o),
    .first_vertex_i      (first_v),
    .second_vertex_i     (second_v),
    .edge_cost_i         (cost_v),
    .restart_i           (restart_v),
    .last_edge_i         (last_v),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall),
    .status_o            (status_o),
    .slot_o              (slot_o),
    .out_first_vertex_o  (out_first_o),
    .out_second_vertex_o (out_second_o),
    .out_cost_o          (out_cost_o),
    .edges_in_tree_o     (edges_in_tree_o),
    .finished_o          (finished_o),
    .cfg_we_i            (cfg_we),
    .cfg_idx_i           (cfg_idx),
    .cfg_data_i          (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // every vertex back to a singleton tree, no accepted edges
  function automatic void clear_forest();
    for (int k = 0; k < MaxVtx; k++) begin
      parent_of[k] = k[9:0];
      tree_sz[k] = SizeW'(1);
    end
    kept = '0;
  endfunction

  // walk parent links up to the root; no path compression
  function automatic int find_root(int node);
    int cur;
    int steps;
    cur = node % MaxVtx;
    steps = 0;
    while (parent_of[cur] != cur && steps < MaxVtx) begin
      cur = parent_of[cur];
      steps++;
    end
    return cur;
  endfunction

  // kruskal step for one edge: updates the shadow forest, returns the verdict
  function automatic verdict_t resolve_edge(edge_item_t e);
    verdict_t v;
    int lim;
    int ra;
    int rb;
    lim = (vtx_count > MaxVtx) ? MaxVtx : int'(vtx_count);
    if (e.restart) clear_forest();
    v = '0;
    if (kept >= tgt_edges) begin
      // forest complete wins over the vertex range check
      v.status = STAT_COMPLETE;
    end else if (e.va == 0 || e.vb == 0 || e.va > lim || e.vb > lim) begin
      v.status = STAT_BAD_VTX;
    end else begin
      ra = find_root(e.va - 1);
      rb = find_root(e.vb - 1);
      if (ra == rb) begin
        // also covers self loops
        v.status = STAT_SAME_TREE;
      end else begin
        // union by size, ties hang the second root under the first
        if (tree_sz[ra] < tree_sz[rb]) begin
          parent_of[ra] = rb[9:0];
          tree_sz[rb] = tree_sz[rb] + tree_sz[ra];
        end else begin
          parent_of[rb] = ra[9:0];
          tree_sz[ra] = tree_sz[ra] + tree_sz[rb];
        end
        v.status = STAT_ACCEPTED;
        v.slot = kept[SlotW-1:0];
        if (kept < 11'd2047) kept++;
      end
    end
    v.va = e.va;
    v.vb = e.vb;
    v.cost = e.cost;
    v.count = kept;
    v.finished = e.last_e || (kept >= tgt_edges);
    return v;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  // input driver: presents queued edges, predicts each one on its transfer
  always @(posedge clk) begin : drive_edges
    edge_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        expected_verdicts.push_back(
          resolve_edge({first_v, second_v, cost_v, restart_v, last_v}));
      end
      // a held edge stays put until its transfer
      if (!in_valid || !in_stall_o) begin
        if (pending_edges.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          nxt = pending_edges.pop_front();
          first_v <= nxt.va;
          second_v <= nxt.vb;
          cost_v <= nxt.cost;
          restart_v <= nxt.restart;
          last_v <= nxt.last_e;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor: random backpressure, checks each transfer against the oldest verdict
  always @(posedge clk) begin : watch_verdicts
    verdict_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, actual status %0d edge %0d-%0d",
                   $time, status_o, out_first_o, out_second_o);
        end else begin
          want = expected_verdicts.pop_front();
          compare_field("status", want.status, status_o);
          compare_field("slot", want.slot, slot_o);
          compare_field("out_first_vertex", want.va, out_first_o);
          compare_field("out_second_vertex", want.vb, out_second_o);
          compare_field("out_cost", want.cost, out_cost_o);
          compare_field("edges_in_tree", want.count, edges_in_tree_o);
          compare_field("finished", want.finished, finished_o);
          n_checked++;
          status_seen[want.status]++;
        end
      end
      out_stall <= ($urandom_range(0, 99) < gap_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("%0t: timeout after %0d cycles, %0d results still expected",
               $time, cycle_count, expected_verdicts.size());
      $display("** kruskal_union_find_edge_filter: FAILED **");
      $finish;
    end
  end

  task automatic queue_edge(int va, int vb, logic [31:0] cost, bit restart, bit last_e);
    edge_item_t e;
    e.va = va[VtxW-1:0];
    e.vb = vb[VtxW-1:0];
    e.cost = cost;
    e.restart = restart;
    e.last_e = last_e;
    pending_edges.push_back(e);
    n_items++;
    // a restart costs a full clearing pass over the forest store
    if (restart) begin
      n_restarts++;
      cycle_limit += 5000;
    end else begin
      cycle_limit += 200;
    end
  endtask

  // wait until every queued edge has gone through and every verdict is back
  task automatic settle();
    while (pending_edges.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(posedge clk);
    cycle_limit += 1000;
    repeat (40) @(posedge clk);
  endtask

  task automatic set_reg(logic [0:0] idx, logic [10:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_VERTEX_COUNT) vtx_count = data;
    else tgt_edges = data[9:0];
    n_writes++;
  endtask

  // one sorted edge list on vertices 1..n, opened by a restart and closed by last_edge;
  // a spanning list holds a random tree plus a few redundant edges
  task automatic queue_graph(int n, bit spanning, int m, bit noisy);
    int ua[$];
    int ub[$];
    int j;
    int k;
    int t;
    int r;
    int x;
    int y;
    logic [31:0] cost;
    if (spanning) begin
      for (j = 2; j <= n; j++) begin
        ua.push_back(j);
        ub.push_back($urandom_range(1, j - 1));
      end
      m = n / 8 + 1;
    end
    for (j = 0; j < m; j++) begin
      ua.push_back($urandom_range(1, n));
      ub.push_back($urandom_range(1, n));
    end
    for (j = ua.size() - 1; j > 0; j--) begin
      k = $urandom_range(0, j);
      t = ua[j]; ua[j] = ua[k]; ua[k] = t;
      t = ub[j]; ub[j] = ub[k]; ub[k] = t;
    end
    cost = $urandom;
    for (j = 0; j < ua.size(); j++) begin
      r = noisy ? $urandom_range(0, 99) : 50;
      x = ua[j];
      y = ub[j];
      // noise: missing vertex, vertex past the count, stray restart
      if (r < 4) x = 0;
      else if (r < 8) y = (n < MaxVtx) ? $urandom_range(n + 1, MaxVtx) : 0;
      if ($urandom_range(0, 1)) begin
        t = x; x = y; y = t;
      end
      cost = cost + $urandom_range(0, 4095);
      queue_edge(x, y, cost, j == 0 || r == 99, j == ua.size() - 1);
    end
  endtask

  initial begin : stimulus
    int p;
    int n;
    int pick;
    int start_items;
    clear_forest();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, 1024 vertices and 1023 wanted edges
    queue_edge(1, 2, 32'h0, 0, 0);
    queue_edge(2, 1, 32'hffff_ffff, 0, 0);     // same tree
    queue_edge(3, 3, 32'h1, 0, 0);             // self loop
    queue_edge(0, 5, 32'h2, 0, 0);
    queue_edge(5, 0, 32'h3, 0, 0);
    queue_edge(0, 0, 32'h4, 0, 0);
    queue_edge(1024, 1, 32'h8000_0000, 0, 0);  // highest vertex
    queue_edge(1024, 1024, 32'h8000_0001, 0, 0);
    queue_edge(7, 8, 32'hffff_fff0, 0, 1);     // last edge of the list
    queue_edge(9, 10, 32'hffff_fff1, 0, 0);    // handled against the same forest
    settle();

    // zero vertices: every endpoint is out of range
    set_reg(CFG_VERTEX_COUNT, 11'd0);
    queue_edge(1, 1, 32'h5a5a_5a5a, 0, 0);
    queue_edge(1024, 3, 32'ha5a5_a5a5, 0, 0);
    settle();

    // count above the store size clamps to it
    set_reg(CFG_VERTEX_COUNT, 11'd2047);
    queue_edge(1024, 5, 32'h1234_5678, 0, 0);
    settle();

    // small forest that completes; bit 10 of the target data is dropped
    set_reg(CFG_VERTEX_COUNT, 11'd4);
    set_reg(CFG_TARGET_EDGES, 11'h402);
    queue_edge(1, 2, 32'h10, 1, 0);
    queue_edge(3, 4, 32'h11, 0, 0);
    queue_edge(1, 3, 32'h12, 0, 0);   // forest complete
    queue_edge(0, 9, 32'h13, 0, 0);   // complete wins over bad vertex
    queue_edge(5, 1, 32'h14, 1, 0);   // restart, then bad vertex
    settle();

    // nothing wanted: complete from the first edge
    set_reg(CFG_TARGET_EDGES, 11'd0);
    queue_edge(1, 2, 32'h20, 0, 0);
    queue_edge(1, 2, 32'h21, 1, 1);
    settle();

    // one full spanning tree over all 1024 vertices, with redundant edges shuffled in
    set_reg(CFG_VERTEX_COUNT, 11'd1024);
    set_reg(CFG_TARGET_EDGES, 11'd1023);
    queue_graph(MaxVtx, 1, 0, 0);
    settle();

    // random settings, mostly small graphs; one phase runs without any idling
    for (p = 0; p < 10; p++) begin
      gap_pct = (p == 4) ? 0 : 26;
      pick = $urandom_range(0, 9);
      if (pick == 0) n = 1;
      else if (pick == 1) n = 2;
      else if (pick == 2) n = MaxVtx;
      else n = $urandom_range(3, 40);
      set_reg(CFG_VERTEX_COUNT, (n == MaxVtx && $urandom_range(0, 1)) ? 11'd2047 : n[10:0]);
      pick = $urandom_range(0, 5);
      if (pick == 0) set_reg(CFG_TARGET_EDGES, 11'($urandom_range(0, n)));
      else if (pick == 1) set_reg(CFG_TARGET_EDGES, 11'd1023);
      else set_reg(CFG_TARGET_EDGES, 11'(n - 1));
      start_items = n_items;
      while (n_items - start_items < 90) begin
        if (n == MaxVtx) queue_graph(n, 0, 60, 1);
        else queue_graph(n, $urandom_range(0, 1), $urandom_range(n, 2 * n), 1);
      end
      settle();
    end

    $display("checked %0d verdicts for %0d edges: %0d merged, %0d same tree, %0d complete, %0d bad",
             n_checked, n_items, status_seen[STAT_ACCEPTED], status_seen[STAT_SAME_TREE],
             status_seen[STAT_COMPLETE], status_seen[STAT_BAD_VTX]);
    $display("%0d register writes, %0d forest restarts, one full 1024-vertex tree",
             n_writes, n_restarts);
    if (errors == 0) begin
      $display("** kruskal_union_find_edge_filter: PASSED **");
    end else begin
      $display("** kruskal_union_find_edge_filter: FAILED **");
    end
    $finish;
  end

endmodule
